[design/dtok_pkg.sv]
// dtok_pkg: shared types and constants for the delimiter tokenizer.
// No dependencies; used by every other design file except dtok_checker.
`timescale 1ns / 1ps

package dtok_pkg;

  // Fixed field widths
  localparam int POS_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 5;
  localparam int INDEX_W = 4;
  localparam int DCNT_W  = 3;

  localparam int DELIM_SLOTS = 6;
  localparam logic [DCNT_W-1:0]  DELIM_SLOTS_C = 3'd6;
  localparam logic [COUNT_W-1:0] TOKEN_LIMIT   = 5'd16;
  localparam logic [POS_W-1:0]   POS_MAX       = 7'd127;

  // Characters with fixed meaning
  localparam logic [CHAR_W-1:0] CH_EOL   = 8'd0;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'd40;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'd41;
  localparam logic [CHAR_W-1:0] CH_WS_LO = 8'd9;
  localparam logic [CHAR_W-1:0] CH_WS_HI = 8'd13;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_DELIM_COUNT = 3'd0;
  localparam logic [2:0] REG_DELIM_0     = 3'd1;
  localparam logic [2:0] REG_DELIM_1     = 3'd2;
  localparam logic [2:0] REG_DELIM_2     = 3'd3;
  localparam logic [2:0] REG_DELIM_3     = 3'd4;
  localparam logic [2:0] REG_DELIM_4     = 3'd5;
  localparam logic [2:0] REG_DELIM_5     = 3'd6;
  localparam logic [2:0] REG_MAX_TOKENS  = 3'd7;

  localparam logic [DCNT_W-1:0]  RST_DELIM_COUNT = 3'd6;
  localparam logic [COUNT_W-1:0] RST_MAX_TOKENS  = 5'd2;
  localparam logic [DELIM_SLOTS-1:0][CHAR_W-1:0] RST_DELIM_CHARS =
    {8'd32, 8'd94, 8'd47, 8'd42, 8'd45, 8'd43};

  typedef struct packed {
    logic [DCNT_W-1:0]                     delim_count;
    logic [DELIM_SLOTS-1:0][CHAR_W-1:0]    delim_char;
    logic [COUNT_W-1:0]                    max_tokens;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]   token_offset;
    logic [POS_W-1:0]   token_length;
    logic [CHAR_W-1:0]  terminator;
    logic [INDEX_W-1:0] token_index;
    logic               token_empty;
    logic               line_done;
    logic [COUNT_W-1:0] token_count;
  } result_t;

endpackage

[design/dtok_if.sv]
// Valid/ready channel interfaces for the tokenizer byte input and token output.
// Depends on dtok_pkg for field widths.
`timescale 1ns / 1ps

interface dtok_in_if;
  logic                       valid;
  logic                       ready;
  logic [dtok_pkg::CHAR_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface dtok_out_if;
  logic                         valid;
  logic                         ready;
  logic [dtok_pkg::POS_W-1:0]   token_offset;
  logic [dtok_pkg::POS_W-1:0]   token_length;
  logic [dtok_pkg::CHAR_W-1:0]  terminator;
  logic [dtok_pkg::INDEX_W-1:0] token_index;
  logic                         token_empty;
  logic                         line_done;
  logic [dtok_pkg::COUNT_W-1:0] token_count;

  modport source (output valid, output token_offset, output token_length,
                  output terminator, output token_index, output token_empty,
                  output line_done, output token_count, input ready);
  modport sink   (input valid, input token_offset, input token_length,
                  input terminator, input token_index, input token_empty,
                  input line_done, input token_count, output ready);
endinterface

[design/dtok_apb_regs.sv]
// dtok_apb_regs: APB-style configuration register file.
// Depends on dtok_pkg (cfg_t, register indexes, reset values).
`timescale 1ns / 1ps

module dtok_apb_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output dtok_pkg::cfg_t      cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delim_count <= dtok_pkg::RST_DELIM_COUNT;
      cfg.delim_char  <= dtok_pkg::RST_DELIM_CHARS;
      cfg.max_tokens  <= dtok_pkg::RST_MAX_TOKENS;
    end else if (wr_en) begin
      unique case (reg_idx)
        dtok_pkg::REG_DELIM_COUNT: cfg.delim_count   <= pwdata[2:0];
        dtok_pkg::REG_DELIM_0:     cfg.delim_char[0] <= pwdata[7:0];
        dtok_pkg::REG_DELIM_1:     cfg.delim_char[1] <= pwdata[7:0];
        dtok_pkg::REG_DELIM_2:     cfg.delim_char[2] <= pwdata[7:0];
        dtok_pkg::REG_DELIM_3:     cfg.delim_char[3] <= pwdata[7:0];
        dtok_pkg::REG_DELIM_4:     cfg.delim_char[4] <= pwdata[7:0];
        dtok_pkg::REG_DELIM_5:     cfg.delim_char[5] <= pwdata[7:0];
        dtok_pkg::REG_MAX_TOKENS:  cfg.max_tokens    <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      dtok_pkg::REG_DELIM_COUNT: prdata = {29'd0, cfg.delim_count};
      dtok_pkg::REG_DELIM_0:     prdata = {24'd0, cfg.delim_char[0]};
      dtok_pkg::REG_DELIM_1:     prdata = {24'd0, cfg.delim_char[1]};
      dtok_pkg::REG_DELIM_2:     prdata = {24'd0, cfg.delim_char[2]};
      dtok_pkg::REG_DELIM_3:     prdata = {24'd0, cfg.delim_char[3]};
      dtok_pkg::REG_DELIM_4:     prdata = {24'd0, cfg.delim_char[4]};
      dtok_pkg::REG_DELIM_5:     prdata = {24'd0, cfg.delim_char[5]};
      dtok_pkg::REG_MAX_TOKENS:  prdata = {27'd0, cfg.max_tokens};
    endcase
  end

endmodule

[design/dtok_parse.sv]
// dtok_parse: per-line parse state and the combinational byte step logic.
// Depends on dtok_pkg (cfg_t, result_t, character constants).
`timescale 1ns / 1ps

module dtok_parse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [dtok_pkg::CHAR_W-1:0]   raw_byte,
  input  dtok_pkg::cfg_t                cfg,
  output logic                          emit,
  output dtok_pkg::result_t             result
);

  localparam logic [2:0] MODE_SKIP  = 3'd0;
  localparam logic [2:0] MODE_TOKEN = 3'd1;
  localparam logic [2:0] MODE_PAREN = 3'd2;
  localparam logic [2:0] MODE_AFTER = 3'd3;  // space seen, waiting for real terminator
  localparam logic [2:0] MODE_DONE  = 3'd4;

  logic [2:0]                    mode, mode_next;
  logic [dtok_pkg::POS_W-1:0]    byte_pos, byte_pos_next;
  logic [dtok_pkg::POS_W-1:0]    cur_start, cur_start_next;
  logic [dtok_pkg::POS_W-1:0]    cur_len, cur_len_next;
  logic [dtok_pkg::COUNT_W-1:0]  tokens, tokens_next;

  logic [dtok_pkg::CHAR_W-1:0]   c;
  logic [dtok_pkg::POS_W-1:0]    pos_inc, len_inc;
  logic [dtok_pkg::DCNT_W-1:0]   n_eff;
  logic [dtok_pkg::COUNT_W-1:0]  limit;
  logic [dtok_pkg::DELIM_SLOTS-1:0] slot_hit;
  logic                          delim_hit;
  logic [dtok_pkg::CHAR_W-1:0]   e_term;
  logic [dtok_pkg::POS_W-1:0]    e_start, e_len;
  logic                          restart;
  logic                          e_empty, e_done;
  logic [dtok_pkg::COUNT_W-1:0]  tf_new;
  logic [2:0]                    start_mode;

  // whitespace folds to space
  assign c = (raw_byte >= dtok_pkg::CH_WS_LO && raw_byte <= dtok_pkg::CH_WS_HI) ?
             dtok_pkg::CH_SPACE : raw_byte;

  assign pos_inc = (byte_pos < dtok_pkg::POS_MAX) ? byte_pos + 7'd1 : byte_pos;
  assign len_inc = (cur_len  < dtok_pkg::POS_MAX) ? cur_len  + 7'd1 : cur_len;

  assign n_eff = (cfg.delim_count > dtok_pkg::DELIM_SLOTS_C) ?
                 dtok_pkg::DELIM_SLOTS_C : cfg.delim_count;

  always_comb begin
    if (cfg.max_tokens == 5'd0)                     limit = 5'd1;
    else if (cfg.max_tokens > dtok_pkg::TOKEN_LIMIT) limit = dtok_pkg::TOKEN_LIMIT;
    else                                             limit = cfg.max_tokens;
  end

  always_comb begin
    for (int k = 0; k < dtok_pkg::DELIM_SLOTS; k++) begin
      slot_hit[k] = (3'(k) < n_eff) && (cfg.delim_char[k] == c);
    end
  end

  assign delim_hit  = (c == dtok_pkg::CH_EOL) || (|slot_hit);
  assign start_mode = (c == dtok_pkg::CH_OPEN) ? MODE_PAREN : MODE_TOKEN;

  always_comb begin
    mode_next      = mode;
    byte_pos_next  = pos_inc;
    cur_start_next = cur_start;
    cur_len_next   = cur_len;
    tokens_next    = tokens;
    emit           = 1'b0;
    e_term         = dtok_pkg::CH_EOL;
    e_start        = cur_start;
    e_len          = cur_len;
    restart        = 1'b0;

    unique case (mode)
      MODE_SKIP: begin
        if (c == dtok_pkg::CH_SPACE) begin
          // skip leading space
        end else if (c != dtok_pkg::CH_OPEN && delim_hit) begin
          emit           = 1'b1;
          e_term         = c;
          e_start        = byte_pos;
          e_len          = '0;
          cur_start_next = byte_pos;
          cur_len_next   = '0;
        end else begin
          cur_start_next = byte_pos;
          cur_len_next   = 7'd1;
          mode_next      = start_mode;
        end
      end
      MODE_TOKEN: begin
        if (delim_hit) begin
          if (c == dtok_pkg::CH_SPACE) begin
            mode_next = MODE_AFTER;
          end else begin
            emit   = 1'b1;
            e_term = c;
          end
        end else begin
          cur_len_next = len_inc;
        end
      end
      MODE_PAREN: begin
        if (c == dtok_pkg::CH_EOL) begin
          emit = 1'b1;
        end else begin
          cur_len_next = len_inc;
          if (c == dtok_pkg::CH_CLOSE) mode_next = MODE_TOKEN;
        end
      end
      MODE_AFTER: begin
        if (c == dtok_pkg::CH_SPACE) begin
          // more spaces after the token
        end else if (delim_hit) begin
          emit   = 1'b1;
          e_term = c;
        end else begin
          // space stands as terminator, this byte opens the next token
          emit    = 1'b1;
          e_term  = dtok_pkg::CH_SPACE;
          restart = 1'b1;
        end
      end
      default: begin
        // limit reached: drop bytes until end of line
        if (c == dtok_pkg::CH_EOL) begin
          mode_next      = MODE_SKIP;
          byte_pos_next  = '0;
          cur_start_next = '0;
          cur_len_next   = '0;
          tokens_next    = '0;
        end
      end
    endcase

    // empty final token is not counted; EOL or the token cap closes the line
    e_empty = (e_term == dtok_pkg::CH_EOL) && (e_len == '0);
    tf_new  = tokens + {4'd0, !e_empty};
    e_done  = (e_term == dtok_pkg::CH_EOL) || (tf_new >= limit);

    if (emit) begin
      tokens_next = tf_new;
      if (e_term == dtok_pkg::CH_EOL) begin
        mode_next      = MODE_SKIP;
        byte_pos_next  = '0;
        cur_start_next = '0;
        cur_len_next   = '0;
        tokens_next    = '0;
      end else if (e_done) begin
        mode_next = MODE_DONE;
      end else if (restart) begin
        cur_start_next = byte_pos;
        cur_len_next   = 7'd1;
        mode_next      = start_mode;
      end else begin
        mode_next = MODE_SKIP;
      end
    end
  end

  assign result.token_offset = e_start;
  assign result.token_length = e_len;
  assign result.terminator   = e_term;
  assign result.token_index  = tokens[dtok_pkg::INDEX_W-1:0];
  assign result.token_empty  = e_empty;
  assign result.line_done    = e_done;
  assign result.token_count  = tf_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_SKIP;
      byte_pos  <= '0;
      cur_start <= '0;
      cur_len   <= '0;
      tokens    <= '0;
    end else if (step) begin
      mode      <= mode_next;
      byte_pos  <= byte_pos_next;
      cur_start <= cur_start_next;
      cur_len   <= cur_len_next;
      tokens    <= tokens_next;
    end
  end

endmodule

[design/delimiter_tokenizer_core.sv]
// delimiter_tokenizer_core: top level of the byte-stream line tokenizer.
// Depends on dtok_pkg, dtok_if, dtok_apb_regs and dtok_parse.
`timescale 1ns / 1ps
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+---------------------------------------------
//  in_ch    | in  | valid/ready     | in_byte
//  out_ch   | out | valid/ready     | token_offset, token_length, terminator,
//           |     |                 | token_index, token_empty, line_done,
//           |     |                 | token_count
//  APB      | in  | psel/penable    | paddr[4:2] = register index, pwdata/prdata
//
//  One byte per cycle sustained while out_ch is not stalled. A byte accepted
//  into the input register is parsed from there; a transaction it completes
//  is loaded into the result register and then offered on out_ch.
//  A stalled out_ch holds parsing; the input register still takes one more
//  byte while a result waits, then in_ch.ready drops.
//  rst is synchronous: clears both pipeline valids and parse state, and loads the config registers' reset values.

module delimiter_tokenizer_core (
  input  logic               clk,
  input  logic               rst,
  dtok_in_if.sink            in_ch,
  dtok_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  dtok_pkg::cfg_t      cfg;
  dtok_pkg::result_t   step_result;
  dtok_pkg::result_t   out_data;
  logic                step_emit;

  // input register
  logic                          in_valid;
  logic [dtok_pkg::CHAR_W-1:0]   in_data;
  // result register
  logic                          out_valid;

  logic advance;   // parse the held byte this cycle
  logic in_take;

  assign advance     = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  dtok_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtok_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .raw_byte (in_data),
    .cfg      (cfg),
    .emit     (step_emit),
    .result   (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data <= in_ch.in_byte;
    end
  end

  // result register: loads only on an emitting step, otherwise clears once out_ch takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_emit) begin
      out_data <= step_result;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.token_offset = out_data.token_offset;
  assign out_ch.token_length = out_data.token_length;
  assign out_ch.terminator   = out_data.terminator;
  assign out_ch.token_index  = out_data.token_index;
  assign out_ch.token_empty  = out_data.token_empty;
  assign out_ch.line_done    = out_data.line_done;
  assign out_ch.token_count  = out_data.token_count;

endmodule

[design/dtok_checker.sv]
// dtok_checker: port-level assertions for delimiter_tokenizer_core, with bind.
// Depends on the top level's ports only.
`timescale 1ns / 1ps

module dtok_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  token_offset,
  input logic [6:0]  token_length,
  input logic [7:0]  terminator,
  input logic [3:0]  token_index,
  input logic        token_empty,
  input logic        line_done,
  input logic [4:0]  token_count
);

  // no transaction offered right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out valid after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_offset) &&
      $stable(token_length) && $stable(terminator) && $stable(token_index) &&
      $stable(token_empty) && $stable(line_done) && $stable(token_count))
    else $error("stalled result changed");

  // end of line always closes the line
  a_eol_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && terminator == 8'd0 |-> line_done)
    else $error("end of line without line_done");

  // empty token only as a zero-length final token at end of line
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_empty |-> line_done && token_length == 7'd0 &&
      terminator == 8'd0 && token_count == {1'b0, token_index})
    else $error("malformed empty token");

  // a counted token advances the count past its index
  a_count_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !token_empty |-> token_count == {1'b0, token_index} + 5'd1)
    else $error("token count does not follow index");

endmodule

bind delimiter_tokenizer_core dtok_checker u_dtok_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .token_offset (out_ch.token_offset),
  .token_length (out_ch.token_length),
  .terminator   (out_ch.terminator),
  .token_index  (out_ch.token_index),
  .token_empty  (out_ch.token_empty),
  .line_done    (out_ch.line_done),
  .token_count  (out_ch.token_count)
);
